FILE: src/fhpa_pkg.sv
// ----------------------------------------------------------------------------
// fhpa_pkg: shared types and constants of the handle pool allocator
// Pool size, field widths, request and status codes, and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package fhpa_pkg;

	localparam int POOL_SIZE = 256;
	localparam int HANDLE_W  = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	localparam int REQ_W     = 2;
	localparam int FH_W      = 8;
	localparam int OUT_H_W   = 8;
	localparam int STATUS_W  = 2;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TRY   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd3;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [CNT_W-1:0]    count_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept_rdy;
		logic capture;
		logic pop_rd;
		logic exec_load;
		logic pop_load;
	} fhpa_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pop_needed;
		logic out_free;
	} fhpa_sts_t;

	// Next slot of the circular free queue.
	function automatic handle_t next_slot(input handle_t slot);
		handle_t nxt;
		if (32'(slot) == POOL_SIZE - 1) begin
			nxt = '0;
		end else begin
			nxt = slot + handle_t'(1);
		end
		return nxt;
	endfunction

	// Handle as reported on the 8-bit result field.
	function automatic logic [OUT_H_W-1:0] out_handle(input handle_t h);
		return OUT_H_W'(h);
	endfunction

endpackage

FILE: src/fhpa_req_if.sv
// ----------------------------------------------------------------------------
// fhpa_req_if: request channel
// Valid/ready channel that carries one allocate, try-allocate or free item.
// ----------------------------------------------------------------------------
interface fhpa_req_if;
	logic                         valid;
	logic                         ready;
	logic [fhpa_pkg::REQ_W-1:0]   req_type;
	logic [fhpa_pkg::FH_W-1:0]    free_handle;

	modport source (output valid, output req_type, output free_handle, input ready);
	modport sink   (input valid, input req_type, input free_handle, output ready);
endinterface

FILE: src/fhpa_res_if.sv
// ----------------------------------------------------------------------------
// fhpa_res_if: result channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
interface fhpa_res_if;
	logic                          valid;
	logic                          ready;
	logic [fhpa_pkg::OUT_H_W-1:0]  granted_handle;
	logic                          granted;
	logic [fhpa_pkg::STATUS_W-1:0] status;

	modport source (output valid, output granted_handle, output granted, output status,
		input ready);
	modport sink   (input valid, input granted_handle, input granted, input status,
		output ready);
endinterface

FILE: src/fhpa_ctrl.sv
// ----------------------------------------------------------------------------
// fhpa_ctrl: request sequencer
// Takes one item at a time, decides between the direct path and the queue
// pop path, and loads the result once the output register is free.
// ----------------------------------------------------------------------------
module fhpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fhpa_pkg::fhpa_sts_t sts,
	output fhpa_pkg::fhpa_cmd_t cmd
);
	import fhpa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept_rdy = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.pop_needed) begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POP;
				end else if (sts.out_free) begin
					cmd.exec_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.pop_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/fhpa_dp.sv
// ----------------------------------------------------------------------------
// fhpa_dp: allocator datapath
// Free queue memory with head, tail and count, the in-use map, the mint
// counter, the request register and the output register.
// ----------------------------------------------------------------------------
module fhpa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fhpa_pkg::REQ_W-1:0]    req_type,
	input  logic [fhpa_pkg::FH_W-1:0]     free_handle,
	input  fhpa_pkg::fhpa_cmd_t           cmd,
	output fhpa_pkg::fhpa_sts_t           sts,
	fhpa_res_if.source                    res
);
	import fhpa_pkg::*;

	handle_t               queue_mem [POOL_SIZE];
	handle_t               rdata_q;

	logic [REQ_W-1:0]      req_q;
	logic [FH_W-1:0]       fh_q;

	handle_t               head_q;
	handle_t               tail_q;
	count_t                count_q;
	count_t                minted_q;
	logic [POOL_SIZE-1:0]  in_use_q;

	logic                  out_valid_q;
	logic [OUT_H_W-1:0]    out_handle_q;
	logic                  out_granted_q;
	logic [STATUS_W-1:0]   out_status_q;

	handle_t               fh_idx;
	logic                  fh_in_range;
	logic                  free_ok;
	logic                  mint_ok;
	logic                  is_alloc;

	assign fh_idx      = handle_t'(fh_q);
	assign fh_in_range = 32'(fh_q) < POOL_SIZE;
	assign free_ok     = fh_in_range && in_use_q[fh_idx];
	assign mint_ok     = 32'(minted_q) < POOL_SIZE;
	assign is_alloc    = (req_q == REQ_ALLOC) || (req_q == REQ_TRY);

	assign sts.pop_needed = is_alloc && (count_q != '0);
	assign sts.out_free   = !out_valid_q || res.ready;

	assign res.valid          = out_valid_q;
	assign res.granted_handle = out_handle_q;
	assign res.granted        = out_granted_q;
	assign res.status         = out_status_q;

	// Request register and queue memory.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			fh_q  <= free_handle;
		end
		if (cmd.exec_load && req_q == REQ_FREE && free_ok) begin
			queue_mem[tail_q] <= fh_idx;
		end
		if (cmd.pop_rd) begin
			rdata_q <= queue_mem[head_q];
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.pop_load) begin
			out_handle_q  <= out_handle(rdata_q);
			out_granted_q <= 1'b1;
			out_status_q  <= ST_OK;
		end else if (cmd.exec_load) begin
			out_handle_q  <= '0;
			out_granted_q <= 1'b0;
			out_status_q  <= ST_OK;
			case (req_q)
				REQ_ALLOC: begin
					if (mint_ok) begin
						out_handle_q  <= out_handle(handle_t'(minted_q));
						out_granted_q <= 1'b1;
					end else begin
						out_status_q <= ST_EXHAUSTED;
					end
				end
				REQ_TRY: begin
					out_status_q <= ST_NO_FREE;
				end
				REQ_FREE: begin
					if (!free_ok) begin
						out_status_q <= ST_NOT_IN_USE;
					end
				end
				default: begin
					out_status_q <= ST_OK;
				end
			endcase
		end
	end

	// Queue pointers, mint counter, in-use map and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			minted_q    <= '0;
			in_use_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop_load || cmd.exec_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.pop_rd) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - count_t'(1);
			end
			if (cmd.pop_load) begin
				in_use_q[rdata_q] <= 1'b1;
			end
			if (cmd.exec_load) begin
				if (req_q == REQ_ALLOC && mint_ok) begin
					in_use_q[handle_t'(minted_q)] <= 1'b1;
					minted_q <= minted_q + count_t'(1);
				end
				if (req_q == REQ_FREE && free_ok) begin
					in_use_q[fh_idx] <= 1'b0;
					tail_q  <= next_slot(tail_q);
					count_q <= count_q + count_t'(1);
				end
			end
		end
	end

endmodule

FILE: src/fifo_handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator: handle allocator with a FIFO free list
// A result is loaded into the output register once its item is in the
// request register; when the handle is popped from the free queue, a read
// of the queue memory into the read-data register comes first.
// The sequencer handles one item at a time: it takes no new item until the
// last item's result is loaded; a stalled output holds that load back.
// Reset clears pointers, counters, the in-use map and the handshake at once;
// no clearing pass is needed and the queue memory is left as it is.
// ----------------------------------------------------------------------------
module fifo_handle_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	fhpa_req_if.sink    req,
	fhpa_res_if.source  res
);
	import fhpa_pkg::*;

	// The sequencer accepts an item only in its idle state. A free or a
	// mint-on-allocate item is resolved in the exec state from the
	// registered map and counters. An allocate that finds freed handles reads
	// the oldest one into the read-data register first and reports it from there.
	// The output register is loaded only when it is empty or being drained,
	// so an item can be accepted while the previous result still waits.

	fhpa_cmd_t cmd;
	fhpa_sts_t sts;

	assign req.ready = cmd.accept_rdy;

	fhpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	fhpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req.req_type),
		.free_handle (req.free_handle),
		.cmd         (cmd),
		.sts         (sts),
		.res         (res)
	);

	// A queue read is always followed by its completion cycle, never by a
	// direct load or a new acceptance.
	a_pop_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |=> !cmd.exec_load && !req.ready)
		else $error("queue pop not followed by its completion cycle");

	// After an item is accepted the block takes no further item the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while previous item in progress");

	// A grant always reports an ok status.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.granted) |-> (res.status == ST_OK))
		else $error("grant with error status");

	// A result is loaded only when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !(cmd.exec_load || cmd.pop_load))
		else $error("output register overwritten while stalled");

endmodule
